FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

	// item field widths
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int IDX_W     = 11;
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_LIN_W = 11;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUT_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT_CELL = 2'd1;
	localparam logic [OP_W-1:0] OP_READ     = 2'd2;

	// control characters
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;

	// register indexes
	localparam logic [0:0] REG_TEXT_FG = 1'b0;
	localparam logic [0:0] REG_TEXT_BG = 1'b1;

	typedef struct packed {
		logic [COLOR_W-1:0] bg;
		logic [COLOR_W-1:0] fg;
		logic [CHAR_W-1:0]  ch;
	} tcw_cell_t;

	localparam tcw_cell_t BLANK_CELL = '{bg: 4'h0, fg: 4'hf, ch: 8'h20};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RD_DIV,
		ST_RD_ADDR,
		ST_SCROLL,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic rd_div;
		logic rd_addr;
		logic sweep;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic is_read;
		logic scroll;
		logic sweep_last_col;
		logic sweep_last_row;
		logic out_free;
	} tcw_sts_t;

endpackage

FILE: hw/rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tcw_sts_t sts,
	output tcw_cmd_t cmd
);

	tcw_state_t state_q;
	tcw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.sweep_last_col && sts.sweep_last_row) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_read) begin
					state_d = ST_RD_DIV;
				end else if (sts.scroll) begin
					state_d = ST_SCROLL;
				end else if (sts.out_free) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RD_DIV:  state_d = ST_RD_ADDR;
			ST_RD_ADDR: state_d = ST_DONE;
			ST_SCROLL: begin
				if (sts.sweep_last_col) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_CLEAR:   cmd.sweep = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.out_load = !sts.is_read && !sts.scroll && sts.out_free;
			end
			ST_RD_DIV:  cmd.rd_div = 1'b1;
			ST_RD_ADDR: cmd.rd_addr = 1'b1;
			ST_SCROLL:  cmd.sweep = 1'b1;
			ST_DONE:    cmd.out_load = sts.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

FILE: hw/rtl/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_cmd_t             cmd,
	output tcw_sts_t             sts,
	input  logic [OP_W-1:0]      op,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [COLOR_W-1:0]   cell_fg_in,
	input  logic [COLOR_W-1:0]   cell_bg_in,
	input  logic [IDX_W-1:0]     read_index,
	input  logic [COLOR_W-1:0]   text_fg,
	input  logic [COLOR_W-1:0]   text_bg,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [OUT_COL_W-1:0] cursor_col,
	output logic [OUT_ROW_W-1:0] cursor_row,
	output logic [OUT_LIN_W-1:0] cursor_linear,
	output logic [CHAR_W-1:0]    read_char,
	output logic [COLOR_W-1:0]   read_fg,
	output logic [COLOR_W-1:0]   read_bg
);

	localparam int CB      = $clog2(COLUMNS);
	localparam int RB      = $clog2(ROWS);
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int LB      = $clog2(CELLS);
	localparam int AW      = RB + CB;
	localparam int DEPTH   = 2 ** AW;
	localparam int SHIFT   = IDX_W + CB;
	localparam int RECIP   = (2 ** SHIFT + COLUMNS - 1) / COLUMNS;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PW      = IDX_W + RECIP_W;
	localparam int QW      = IDX_W - 3;

	// rows are kept as a ring, top_q is the physical row shown on top
	function automatic logic [RB-1:0] to_phys(input logic [RB-1:0] r, input logic [RB-1:0] t);
		logic [RB:0] s;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (RB+1)'(ROWS)) begin
			s = s - (RB+1)'(ROWS);
		end
		return s[RB-1:0];
	endfunction

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [CHAR_W-1:0]  ch_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic [IDX_W-1:0]   idx_q;

	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [LB-1:0] lin_q;
	logic [RB-1:0] top_q;
	logic [CB-1:0] swp_col_q;
	logic [RB-1:0] swp_row_q;

	logic [PW-1:0] prod_s1;
	logic [QW-1:0] quo_s2;
	logic [CB-1:0] rem_s2;
	logic          ok_s2;
	tcw_cell_t     rdata_q;

	tcw_cell_t mem [DEPTH];

	logic                 out_valid_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [OUT_LIN_W-1:0] out_lin_q;
	tcw_cell_t            out_cell_q;

	// put execution
	logic          is_put;
	logic [CB-1:0] col_nx;
	logic [RB-1:0] row_nx;
	logic [LB-1:0] lin_nx;
	logic          scroll_nx;
	logic          adv_row;
	logic [CB:0]   col_sum;
	logic          wr;
	logic [RB-1:0] wr_row;
	logic [CB-1:0] wr_col;
	tcw_cell_t     wr_cell;

	logic [CB-1:0] col_d;
	logic [RB-1:0] row_d;
	logic [LB-1:0] lin_d;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	tcw_cell_t       mem_wdata;
	logic [AW-1:0]   mem_raddr;

	logic [QW-1:0]    quo_raw;
	logic [IDX_W-1:0] rem_raw;
	logic             rd_hit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			ch_q  <= char_code;
			fg_q  <= (op == OP_PUT_CHAR) ? text_fg : cell_fg_in;
			bg_q  <= (op == OP_PUT_CHAR) ? text_bg : cell_bg_in;
			idx_q <= read_index;
		end
	end

	always_comb begin
		is_put    = (op_q == OP_PUT_CHAR) || (op_q == OP_PUT_CELL);
		col_nx    = col_q;
		row_nx    = row_q;
		lin_nx    = lin_q;
		scroll_nx = 1'b0;
		adv_row   = 1'b0;
		col_sum   = {1'b0, col_q} + (CB+1)'(TAB_STEP);
		wr        = 1'b0;
		wr_row    = row_q;
		wr_col    = col_q;
		wr_cell   = '{bg: bg_q, fg: fg_q, ch: ch_q};
		if (is_put) begin
			case (ch_q)
				CH_LF: begin
					col_nx  = '0;
					adv_row = 1'b1;
					lin_nx  = lin_q - LB'(col_q) + LB'(COLUMNS);
				end
				CH_TAB: begin
					if (col_sum >= (CB+1)'(COLUMNS)) begin
						col_nx  = '0;
						adv_row = 1'b1;
						lin_nx  = lin_q - LB'(col_q) + LB'(COLUMNS);
					end else begin
						col_nx = col_sum[CB-1:0];
						lin_nx = lin_q + LB'(TAB_STEP);
					end
				end
				CH_CR: begin
					col_nx = '0;
					lin_nx = lin_q - LB'(col_q);
				end
				CH_NUL: begin
					col_nx = col_q;
				end
				CH_BS: begin
					// erase the cell before the cursor, stepping back over a row start
					if ((row_q != '0) || (col_q != '0)) begin
						wr      = 1'b1;
						wr_cell = BLANK_CELL;
						lin_nx  = lin_q - LB'(1);
						if (col_q == '0) begin
							wr_row = row_q - RB'(1);
							wr_col = CB'(COLUMNS - 1);
							row_nx = row_q - RB'(1);
							col_nx = CB'(COLUMNS - 1);
						end else begin
							wr_col = col_q - CB'(1);
							col_nx = col_q - CB'(1);
						end
					end
				end
				default: begin
					wr     = 1'b1;
					lin_nx = lin_q + LB'(1);
					if (col_q == CB'(COLUMNS - 1)) begin
						col_nx  = '0;
						adv_row = 1'b1;
					end else begin
						col_nx = col_q + CB'(1);
					end
				end
			endcase
			if (adv_row) begin
				if (row_q == RB'(ROWS - 1)) begin
					scroll_nx = 1'b1;
					row_nx    = RB'(ROWS - 1);
					lin_nx    = LB'((ROWS - 1) * COLUMNS);
				end else begin
					row_nx = row_q + RB'(1);
				end
			end
		end
	end

	assign col_d = cmd.exec ? col_nx : col_q;
	assign row_d = cmd.exec ? row_nx : row_q;
	assign lin_d = cmd.exec ? lin_nx : lin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			lin_q     <= '0;
			top_q     <= '0;
			swp_col_q <= '0;
			swp_row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
			lin_q <= lin_d;
			if (cmd.exec && scroll_nx) begin
				top_q     <= (top_q == RB'(ROWS - 1)) ? '0 : top_q + RB'(1);
				swp_row_q <= top_q;
				swp_col_q <= '0;
			end else if (cmd.sweep) begin
				if (swp_col_q == CB'(COLUMNS - 1)) begin
					swp_col_q <= '0;
					swp_row_q <= (swp_row_q == RB'(ROWS - 1)) ? '0 : swp_row_q + RB'(1);
				end else begin
					swp_col_q <= swp_col_q + CB'(1);
				end
			end
		end
	end

	// read index split into row and column by reciprocal multiply
	assign quo_raw = QW'(prod_s1 >> SHIFT);
	assign rem_raw = idx_q - IDX_W'(quo_raw) * IDX_W'(COLUMNS);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			prod_s1 <= PW'(idx_q) * PW'(RECIP);
		end
		if (cmd.rd_div) begin
			ok_s2 <= int'(idx_q) < CELLS;
			if (rem_raw >= IDX_W'(COLUMNS)) begin
				quo_s2 <= quo_raw + QW'(1);
				rem_s2 <= CB'(rem_raw - IDX_W'(COLUMNS));
			end else begin
				quo_s2 <= quo_raw;
				rem_s2 <= CB'(rem_raw);
			end
		end
	end

	assign mem_we    = cmd.sweep || (cmd.exec && wr);
	assign mem_waddr = cmd.sweep ? {swp_row_q, swp_col_q} : {to_phys(wr_row, top_q), wr_col};
	assign mem_wdata = cmd.sweep ? BLANK_CELL : wr_cell;
	assign mem_raddr = {to_phys(RB'(quo_s2), top_q), rem_s2};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_addr) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign rd_hit = (op_q == OP_READ) && ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col_q  <= OUT_COL_W'(col_d);
			out_row_q  <= OUT_ROW_W'(row_d);
			out_lin_q  <= OUT_LIN_W'(lin_d);
			out_cell_q <= rd_hit ? rdata_q : '0;
		end
	end

	assign sts.is_read        = (op_q == OP_READ);
	assign sts.scroll         = scroll_nx;
	assign sts.sweep_last_col = (swp_col_q == CB'(COLUMNS - 1));
	assign sts.sweep_last_row = (swp_row_q == RB'(ROWS - 1));
	assign sts.out_free       = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_linear = out_lin_q;
	assign read_char     = out_cell_q.ch;
	assign read_fg       = out_cell_q.fg;
	assign read_bg       = out_cell_q.bg;

endmodule

FILE: hw/rtl/text_console_writer.sv
// a put transaction (printable or control) is an accept plus an execute into the result register;
// a read steps through accept, multiply, divide fixup, cell memory read and result
// a put that scrolls adds a blanking step while the single write port blanks the vacated row
// throughput: one transaction at a time, next accept in the cycle after the result is loaded
// reset: cursor to top-left, colors to fg 15 bg 0, then a clearing pass over every cell
// blanks the cell memory with input held off; config writes are taken throughout
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // char_code, cell_fg_in, cell_bg_in, read_index, zero pad
	input  logic [1:0]  s_axis_tuser,   // op
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // cursor_col, cursor_row, cursor_linear, read_char,
	                                    // read_fg, read_bg, zero pad
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// color registers used by put-char transactions
	logic [COLOR_W-1:0] text_fg_q;
	logic [COLOR_W-1:0] text_bg_q;
	logic               cfg_wr;

	tcw_cmd_t cmd;
	tcw_sts_t sts;

	// unpacked result fields
	logic [OUT_COL_W-1:0] cursor_col;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [OUT_LIN_W-1:0] cursor_linear;
	logic [CHAR_W-1:0]    read_char;
	logic [COLOR_W-1:0]   read_fg;
	logic [COLOR_W-1:0]   read_bg;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// registers sit on word addresses, the low address bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_fg_q <= 4'hf;
			text_bg_q <= 4'h0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TEXT_FG: text_fg_q <= pwdata[COLOR_W-1:0];
				REG_TEXT_BG: text_bg_q <= pwdata[COLOR_W-1:0];
				default:     text_fg_q <= text_fg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TEXT_FG: prdata = 32'(text_fg_q);
			REG_TEXT_BG: prdata = 32'(text_bg_q);
			default:     prdata = '0;
		endcase
	end

	// sequencer: clearing pass, execute, read steps, row blanking, result hand-off
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cursor, ring-ordered cell memory, index divider and result register
	tcw_datapath #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STEP (TAB_STEP)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (s_axis_tuser),
		.char_code     (s_axis_tdata[7:0]),
		.cell_fg_in    (s_axis_tdata[11:8]),
		.cell_bg_in    (s_axis_tdata[15:12]),
		.read_index    (s_axis_tdata[26:16]),
		.text_fg       (text_fg_q),
		.text_bg       (text_bg_q),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_linear (cursor_linear),
		.read_char     (read_char),
		.read_fg       (read_fg),
		.read_bg       (read_bg)
	);

	assign m_axis_tdata = {1'b0, read_bg, read_fg, read_char, cursor_linear, cursor_row,
		cursor_col};

	// one transaction in flight: no second accept right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a transaction is in flight");

	// a result is only loaded when the result register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken result");

	// the blanking sweep owns the memory port
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !(cmd.exec || cmd.rd_addr || s_axis_tready))
		else $error("memory access during row blanking");

	// a loaded result shows up on the result stream
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");

endmodule
